// ===== rtl/core/cfp_pkg.sv =====
`default_nettype none

package cfp_pkg;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Frame = 2 start bytes + 2 length bytes + 4 body prefix + payload + 2 CRC
	localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
	localparam logic [15:0] BODY_PREFIX    = 16'd4;

	localparam int PLEN_W   = 13;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 4'd3;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_DATA   = 2'd1,
		OP_ERROR  = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  msg_id;
		logic [7:0]  seq_num;
		logic [7:0]  flag_bits;
		logic [15:0] body_bytes;
		logic [7:0]  data_byte;
		logic        has_data;   // header command also carries the first payload byte
		logic        finish;     // CRC trailer follows this command
	} cmd_t;

	typedef struct packed {
		logic [7:0] start_first;
		logic [7:0] start_second;
		logic [7:0] version;
	} hdr_cfg_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfp_front.sv =====
`default_nettype none

// Classifies accepted items into commands; tracks frame position.
module cfp_front #(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [7:0]                  msg_id,
	input  wire logic [7:0]                  seq_num,
	input  wire logic [7:0]                  flag_bits,
	input  wire logic [cfp_pkg::PLEN_W-1:0]  payload_bytes,
	input  wire logic [7:0]                  data_byte,
	input  wire logic [15:0]                 max_frame_len,
	output logic                             cmd_push,
	output cfp_pkg::cmd_t                    cmd
);

	logic                       in_frame_q;
	logic                       dropping_q;
	logic [cfp_pkg::PLEN_W-1:0] bytes_left_q;

	logic [16:0]                plen_ext;
	logic                       too_long;
	logic                       push_c;
	logic                       in_frame_d;
	logic                       dropping_d;
	logic [cfp_pkg::PLEN_W-1:0] bytes_left_d;
	logic [cfp_pkg::PLEN_W-1:0] left_dec;
	logic [cfp_pkg::PLEN_W-1:0] plen_dec;

	always_comb begin
		plen_ext = {4'b0, payload_bytes};
		too_long = (plen_ext > 17'(MAX_PAYLOAD)) ||
			((plen_ext + cfp_pkg::FRAME_OVERHEAD) > {1'b0, max_frame_len});
		left_dec = bytes_left_q - cfp_pkg::PLEN_W'(1);
		plen_dec = payload_bytes - cfp_pkg::PLEN_W'(1);

		cmd.op         = cfp_pkg::OP_DATA;
		cmd.msg_id     = msg_id;
		cmd.seq_num    = seq_num;
		cmd.flag_bits  = flag_bits;
		cmd.body_bytes = 16'(payload_bytes) + cfp_pkg::BODY_PREFIX;
		cmd.data_byte  = data_byte;
		cmd.has_data   = 1'b1;
		cmd.finish     = 1'b0;

		push_c       = 1'b0;
		in_frame_d   = in_frame_q;
		dropping_d   = dropping_q;
		bytes_left_d = bytes_left_q;

		if (!in_frame_q) begin
			push_c = 1'b1;
			if (too_long) begin
				cmd.op = cfp_pkg::OP_ERROR;
				if (payload_bytes > cfp_pkg::PLEN_W'(1)) begin
					in_frame_d   = 1'b1;
					dropping_d   = 1'b1;
					bytes_left_d = plen_dec;
				end
			end else begin
				cmd.op       = cfp_pkg::OP_HEADER;
				cmd.has_data = (payload_bytes != '0);
				cmd.finish   = (payload_bytes <= cfp_pkg::PLEN_W'(1));
				in_frame_d   = (payload_bytes > cfp_pkg::PLEN_W'(1));
				dropping_d   = 1'b0;
				bytes_left_d = (payload_bytes != '0) ? plen_dec : '0;
			end
		end else if (dropping_q) begin
			// rest of a rejected frame: swallowed
			bytes_left_d = left_dec;
			if (left_dec == '0) begin
				in_frame_d = 1'b0;
				dropping_d = 1'b0;
			end
		end else begin
			push_c       = 1'b1;
			cmd.finish   = (left_dec == '0);
			bytes_left_d = left_dec;
			if (left_dec == '0) begin
				in_frame_d = 1'b0;
			end
		end
	end

	assign cmd_push = accept && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			dropping_q   <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			in_frame_q   <= in_frame_d;
			dropping_q   <= dropping_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cfp_cmd_queue.sv =====
`default_nettype none

// Small command FIFO between front and back.
module cfp_cmd_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire cfp_pkg::cmd_t wr_cmd,
	output logic         full,
	input  wire logic    rd_en,
	output cfp_pkg::cmd_t rd_cmd,
	output logic         empty
);

	cfp_pkg::cmd_t             slot_q [cfp_pkg::CMDQ_DEPTH];
	logic [cfp_pkg::CMDQ_AW-1:0] wr_ptr_q;
	logic [cfp_pkg::CMDQ_AW-1:0] rd_ptr_q;
	logic [cfp_pkg::CMDQ_AW:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == (cfp_pkg::CMDQ_AW+1)'(cfp_pkg::CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + cfp_pkg::CMDQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + cfp_pkg::CMDQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (cfp_pkg::CMDQ_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (cfp_pkg::CMDQ_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cfp_back.sv =====
`default_nettype none

// Expands commands into frame bytes, one per cycle unless the output stalls, and runs the CRC.
module cfp_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfp_pkg::hdr_cfg_t cfg,
	input  wire logic       q_empty,
	input  wire cfp_pkg::cmd_t q_cmd,
	output logic            q_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            last_byte,
	output logic            error
);

	typedef enum logic [11:0] {
		ST_SOF1 = 12'b0000_0000_0001,
		ST_SOF2 = 12'b0000_0000_0010,
		ST_LENH = 12'b0000_0000_0100,
		ST_LENL = 12'b0000_0000_1000,
		ST_VER  = 12'b0000_0001_0000,
		ST_MSG  = 12'b0000_0010_0000,
		ST_SEQ  = 12'b0000_0100_0000,
		ST_FLG  = 12'b0000_1000_0000,
		ST_DATA = 12'b0001_0000_0000,
		ST_CRCH = 12'b0010_0000_0000,
		ST_CRCL = 12'b0100_0000_0000,
		ST_ERR  = 12'b1000_0000_0000
	} step_t;

	logic          cmd_valid_q;
	cfp_pkg::cmd_t cmd_q;
	step_t         step_q;
	logic [15:0]   crc_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_err_q;

	logic        out_ready;
	logic        fire;
	logic        load;
	logic [7:0]  byte_c;
	logic        last_c;
	logic        err_c;
	logic        crc_upd;
	logic        done_c;
	step_t       step_nxt;
	step_t       step_start;
	logic [15:0] crc_base;

	assign out_ready = !out_valid_q || pop;
	assign fire      = cmd_valid_q && out_ready;
	assign load      = !cmd_valid_q || (fire && done_c);
	assign q_pop     = load && !q_empty;
	assign crc_base  = (step_q == ST_SOF1) ? cfp_pkg::CRC_INIT : crc_q;

	always_comb begin
		byte_c   = 8'h00;
		last_c   = 1'b0;
		err_c    = 1'b0;
		crc_upd  = 1'b1;
		done_c   = 1'b0;
		step_nxt = step_q;
		case (step_q)
			ST_SOF1: begin
				byte_c   = cfg.start_first;
				step_nxt = ST_SOF2;
			end
			ST_SOF2: begin
				byte_c   = cfg.start_second;
				step_nxt = ST_LENH;
			end
			ST_LENH: begin
				byte_c   = cmd_q.body_bytes[15:8];
				step_nxt = ST_LENL;
			end
			ST_LENL: begin
				byte_c   = cmd_q.body_bytes[7:0];
				step_nxt = ST_VER;
			end
			ST_VER: begin
				byte_c   = cfg.version;
				step_nxt = ST_MSG;
			end
			ST_MSG: begin
				byte_c   = cmd_q.msg_id;
				step_nxt = ST_SEQ;
			end
			ST_SEQ: begin
				byte_c   = cmd_q.seq_num;
				step_nxt = ST_FLG;
			end
			ST_FLG: begin
				byte_c = cmd_q.flag_bits;
				if (cmd_q.has_data) begin
					step_nxt = ST_DATA;
				end else if (cmd_q.finish) begin
					step_nxt = ST_CRCH;
				end else begin
					done_c = 1'b1;
				end
			end
			ST_DATA: begin
				byte_c = cmd_q.data_byte;
				if (cmd_q.finish) begin
					step_nxt = ST_CRCH;
				end else begin
					done_c = 1'b1;
				end
			end
			ST_CRCH: begin
				byte_c   = crc_q[15:8];
				crc_upd  = 1'b0;
				step_nxt = ST_CRCL;
			end
			ST_CRCL: begin
				byte_c  = crc_q[7:0];
				last_c  = 1'b1;
				crc_upd = 1'b0;
				done_c  = 1'b1;
			end
			ST_ERR: begin
				last_c  = 1'b1;
				err_c   = 1'b1;
				crc_upd = 1'b0;
				done_c  = 1'b1;
			end
			default: begin
				crc_upd = 1'b0;
				done_c  = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (q_cmd.op)
			cfp_pkg::OP_HEADER: step_start = ST_SOF1;
			cfp_pkg::OP_DATA:   step_start = ST_DATA;
			cfp_pkg::OP_ERROR:  step_start = ST_ERR;
			default:            step_start = ST_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			step_q      <= ST_SOF1;
			crc_q       <= cfp_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cmd_valid_q <= !q_empty;
				step_q      <= step_start;
			end else if (fire) begin
				step_q <= step_nxt;
			end
			if (fire && crc_upd) begin
				crc_q <= cfp_pkg::crc16_byte(crc_base, byte_c);
			end
			if (out_ready) begin
				out_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
		end
		if (fire) begin
			out_byte_q <= byte_c;
			out_last_q <= last_c;
			out_err_q  <= err_c;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = out_last_q;
	assign error     = out_err_q;

endmodule

`default_nettype wire

// ===== rtl/core/crc16_frame_packer_unit.sv =====
`default_nettype none

// Frame packer with CRC-16/CCITT-FALSE trailer.
// Input channel (push/full): one transaction per payload byte. The first
// transaction of a frame also carries msg_id, seq_num, flag_bits and
// payload_bytes; an empty payload is one transaction whose data_byte is unused.
// Output channel (empty/pop): one transaction per frame byte; last_byte marks
// the CRC low byte, error (with last_byte) marks a rejected oversize frame,
// whose remaining input transactions are then swallowed without output.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects start
// bytes, version or max frame length; write only while the block is idle.
// Path: command queue, then back-end command register, then output register.
// Throughput: payload transactions flow at 1 per cycle. A frame's first
// transaction makes up to 11 output bytes (8 header, data, 2 CRC) and the
// last one 3; the back end emits one byte per cycle while the receiver pops,
// so input stalls once the 4-entry command queue fills behind a header burst.
// Reset: asynchronous, clears frame tracking, queue and output register;
// config registers return to 0xAA, 0x55, 0x01 and 4106.
// Receiver stall: output register holds; the queue absorbs up to 4 commands,
// then full rises.
module crc16_frame_packer_unit #(
	parameter int unsigned MAX_PAYLOAD = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input item channel
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [7:0]                     msg_id,
	input  wire logic [7:0]                     seq_num,
	input  wire logic [7:0]                     flag_bits,
	input  wire logic [cfp_pkg::PLEN_W-1:0]     payload_bytes,
	input  wire logic [7:0]                     data_byte,
	// result channel
	output logic                                empty,
	input  wire logic                           pop,
	output logic [7:0]                          out_byte,
	output logic                                last_byte,
	output logic                                error,
	// config write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cfp_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]  start_first_q;
	logic [7:0]  start_second_q;
	logic [7:0]  version_q;
	logic [15:0] max_len_q;

	logic              accept;
	logic              cmd_push;
	cfp_pkg::cmd_t     front_cmd;
	cfp_pkg::cmd_t     head_cmd;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	cfp_pkg::hdr_cfg_t hdr_cfg;

	assign cfg_ready = 1'b1;

	// Config writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= 8'hAA;
			start_second_q <= 8'h55;
			version_q      <= 8'h01;
			max_len_q      <= 16'd4106;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cfp_pkg::REG_START_FIRST:  start_first_q  <= cfg_data[7:0];
				cfp_pkg::REG_START_SECOND: start_second_q <= cfg_data[7:0];
				cfp_pkg::REG_VERSION:      version_q      <= cfg_data[7:0];
				cfp_pkg::REG_MAX_LEN:      max_len_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hdr_cfg.start_first  = start_first_q;
	assign hdr_cfg.start_second = start_second_q;
	assign hdr_cfg.version      = version_q;

	// Every transaction, even a swallowed one, waits for queue room.
	assign full   = q_full;
	assign accept = push && !q_full;

	cfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.msg_id       (msg_id),
		.seq_num      (seq_num),
		.flag_bits    (flag_bits),
		.payload_bytes(payload_bytes),
		.data_byte    (data_byte),
		.max_frame_len(max_len_q),
		.cmd_push     (cmd_push),
		.cmd          (front_cmd)
	);

	cfp_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (head_cmd),
		.empty  (q_empty)
	);

	cfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (hdr_cfg),
		.q_empty  (q_empty),
		.q_cmd    (head_cmd),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last_byte(last_byte),
		.error    (error)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cfp_checker.sv =====
`default_nettype none

module cfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_byte,
	input wire logic       last_byte,
	input wire logic       error
);

	// nothing to show right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result shown right after reset");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> last_byte)
		else $error("error result without last_byte");

	a_err_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> (out_byte == 8'h00))
		else $error("error result with nonzero byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)
			&& $stable(error)))
		else $error("stalled result changed");

endmodule

bind crc16_frame_packer_unit cfp_checker u_cfp_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

	localparam int PAYLOAD_CAP   = 4096;
	// output path and queue drain slack; covers swallowed transactions too
	localparam int SETTLE_CYCLES = 8;
	// cycles without any transaction on any channel before we give up
	localparam int QUIET_LIMIT   = 2000;
	localparam int ITEM_GOAL     = 420;
	// transactions sent by the directed part, left out of the random budget
	localparam int DIRECTED_ITEMS = 74;
	localparam int REPORT_MAX    = 10;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_GEN  = 16'h1021;
	// index past the register list; a write there must change nothing
	localparam logic [cfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

	typedef struct packed {
		logic [7:0] val;
		logic       last;
		logic       err;
	} frame_byte_t;

	// Tracks framing state and registers, and holds the byte stream the block owes.
	class frame_scoreboard;
		logic [7:0]  start_first;
		logic [7:0]  start_second;
		logic [7:0]  version;
		logic [15:0] max_len;
		bit          in_frame;
		bit          dropping;
		logic [12:0] bytes_left;
		logic [15:0] crc;
		frame_byte_t due[$];
		int          bad_count;

		function new();
			start_first  = 8'hAA;
			start_second = 8'h55;
			version      = 8'h01;
			max_len      = 16'd4106;
			in_frame     = 0;
			dropping     = 0;
			bytes_left   = '0;
			crc          = CRC_SEED;
			bad_count    = 0;
		endfunction

		function void set_reg(logic [cfp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				cfp_pkg::REG_START_FIRST: begin
					start_first = val[7:0];
				end
				cfp_pkg::REG_START_SECOND: begin
					start_second = val[7:0];
				end
				cfp_pkg::REG_VERSION: begin
					version = val[7:0];
				end
				cfp_pkg::REG_MAX_LEN: begin
					max_len = val;
				end
				default: begin
				end
			endcase
		endfunction

		// bit-serial CCITT update, MSB first
		function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int k = 7; k >= 0; k--) begin
				fb = c[15] ^ b[k];
				c = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CRC_GEN;
				end
			end
			return c;
		endfunction

		function void put_byte(logic [7:0] b, logic l, logic e);
			frame_byte_t fb;
			fb.val  = b;
			fb.last = l;
			fb.err  = e;
			due.push_back(fb);
		endfunction

		function void put_summed(logic [7:0] b);
			crc = crc_next(crc, b);
			put_byte(b, 1'b0, 1'b0);
		endfunction

		function void put_trailer();
			put_byte(crc[15:8], 1'b0, 1'b0);
			put_byte(crc[7:0], 1'b1, 1'b0);
			crc = CRC_SEED;
			in_frame = 0;
		endfunction

		function void take_item(logic [7:0] msg, logic [7:0] seq, logic [7:0] flg,
			logic [12:0] plen, logic [7:0] data);
			logic [15:0] body;
			logic [16:0] total;
			if (!in_frame) begin
				body  = {3'b000, plen} + 16'd4;
				total = {4'b0000, plen} + 17'd10;
				crc   = CRC_SEED;
				if (plen > PAYLOAD_CAP || total > {1'b0, max_len}) begin
					// oversize: single error byte, rest of the frame is swallowed
					put_byte(8'h00, 1'b1, 1'b1);
					if (plen > 1) begin
						in_frame   = 1;
						dropping   = 1;
						bytes_left = plen - 13'd1;
					end
					return;
				end
				put_summed(start_first);
				put_summed(start_second);
				put_summed(body[15:8]);
				put_summed(body[7:0]);
				put_summed(version);
				put_summed(msg);
				put_summed(seq);
				put_summed(flg);
				in_frame = 1;
				dropping = 0;
				if (plen == 0) begin
					put_trailer();
					return;
				end
				put_summed(data);
				bytes_left = plen - 13'd1;
				if (bytes_left == 0) begin
					put_trailer();
				end
				return;
			end
			if (dropping || bytes_left == 0) begin
				if (bytes_left > 0) begin
					bytes_left--;
				end
				if (bytes_left == 0) begin
					in_frame = 0;
					dropping = 0;
					crc      = CRC_SEED;
				end
				return;
			end
			put_summed(data);
			bytes_left--;
			if (bytes_left == 0) begin
				put_trailer();
			end
		endfunction

		function void check_byte(logic [7:0] b, logic l, logic e);
			frame_byte_t want;
			if (due.size() == 0) begin
				bad_count++;
				if (bad_count <= REPORT_MAX) begin
					$display("unexpected output byte %02h last %b err %b", b, l, e);
				end
				return;
			end
			want = due.pop_front();
			if (want.val !== b || want.last !== l || want.err !== e) begin
				bad_count++;
				if (bad_count <= REPORT_MAX) begin
					$display("output mismatch: expected byte %02h last %b err %b, got %02h %b %b",
						want.val, want.last, want.err, b, l, e);
				end
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           push          = 1'b0;
	logic                           full;
	logic [7:0]                     msg_id        = '0;
	logic [7:0]                     seq_num       = '0;
	logic [7:0]                     flag_bits     = '0;
	logic [cfp_pkg::PLEN_W-1:0]     payload_bytes = '0;
	logic [7:0]                     data_byte     = '0;
	logic                           empty;
	logic                           pop           = 1'b0;
	logic [7:0]                     out_byte;
	logic                           last_byte;
	logic                           error;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [cfp_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

	frame_scoreboard sb;
	int tx_idle_pct = 30;  // chance of a gap after each input transaction
	int rx_stall_pct = 30; // chance of starting a stall on the result side
	int rx_hold = 0;
	int quiet = 0;

	crc16_frame_packer_unit #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.msg_id       (msg_id),
		.seq_num      (seq_num),
		.flag_bits    (flag_bits),
		.payload_bytes(payload_bytes),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Gap lengths come from three ranges: the shortest mostly, the middle one sometimes, the longest rarely.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80) begin
			return $urandom_range(3, 1);
		end
		if (roll < 96) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	// Result side. All sampling uses pre-edge values, so a transaction here is
	// exactly what the block saw at this edge. Pop while empty is harmless.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				sb.check_byte(out_byte, last_byte, error);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				rx_hold = idle_len() - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: any transaction on any channel resets the quiet counter.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// One input transaction. push stays high into the next call unless a gap
	// is drawn, so back-to-back items never toggle push within a step.
	task automatic send_item(input logic [7:0] m, input logic [7:0] s,
		input logic [7:0] f, input logic [12:0] n, input logic [7:0] d);
		push          <= 1'b1;
		msg_id        <= m;
		seq_num       <= s;
		flag_bits     <= f;
		payload_bytes <= n;
		data_byte     <= d;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sb.take_item(m, s, f, n, d);
		if ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	// Whole frame: header transaction, then payload transactions carrying
	// junk in the header fields (the block must ignore them).
	task automatic send_frame(input logic [7:0] m, input logic [7:0] s,
		input logic [7:0] f, input logic [12:0] n);
		int cnt;
		cnt = (n == 0) ? 1 : int'(n);
		send_item(m, s, f, n, 8'($urandom));
		for (int i = 1; i < cnt; i++) begin
			send_item(8'($urandom), 8'($urandom), 8'($urandom), 13'($urandom),
				8'($urandom));
		end
	endtask

	// Sender holds off until every owed byte is out, then lets any swallowed
	// transactions finish inside the block.
	task automatic go_idle();
		push <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_reg(input logic [cfp_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly legal frames with random content; a tenth oversize where the
	// length limit leaves room for that cheaply; occasional full drain.
	// The budget counts every input transaction sent.
	task automatic random_frames(input int goal);
		int          done;
		int          cap;
		int          roll;
		logic [12:0] n;
		done = 0;
		if (sb.max_len < 16'd10) begin
			cap = -1;
		end else begin
			cap = int'(sb.max_len) - 10;
			if (cap > PAYLOAD_CAP) begin
				cap = PAYLOAD_CAP;
			end
		end
		while (done < goal) begin
			roll = $urandom_range(99);
			if (cap < 0) begin
				n = 13'($urandom_range(12));
			end else if (roll < 10 && cap < PAYLOAD_CAP) begin
				n = 13'($urandom_range(cap + 16, cap + 1));
			end else if (roll < 80) begin
				n = 13'($urandom_range(cap < 12 ? cap : 12));
			end else begin
				n = 13'($urandom_range(cap < 64 ? cap : 64));
			end
			send_frame(8'($urandom), 8'($urandom), 8'($urandom), n);
			done += (n != 0) ? int'(n) : 1;
			if ($urandom_range(19) == 0) begin
				go_idle();
			end
		end
	endtask

	task automatic random_config(input logic [15:0] limit);
		go_idle();
		write_reg(cfp_pkg::REG_START_FIRST, 16'($urandom));
		write_reg(cfp_pkg::REG_START_SECOND, 16'($urandom));
		write_reg(cfp_pkg::REG_VERSION, 16'($urandom));
		write_reg(cfp_pkg::REG_MAX_LEN, limit);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: empty payloads with data ignored, one-byte
		// payloads at both data extremes, then a short frame with junk headers.
		send_item(8'h00, 8'h00, 8'h00, 13'd0, 8'hFF);
		send_item(8'hFF, 8'hFF, 8'hFF, 13'd0, 8'h00);
		send_item(8'h12, 8'h34, 8'h56, 13'd1, 8'h00);
		send_item(8'hA5, 8'h5A, 8'hC3, 13'd1, 8'hFF);
		send_item(8'h01, 8'h80, 8'h7F, 13'd3, 8'h00);
		send_item(8'hFF, 8'hFF, 8'hFF, 13'h1FFF, 8'hFF);
		send_item(8'h00, 8'h00, 8'h00, 13'd0, 8'h5A);

		// Marker/version extremes (upper data bits must be dropped), tight length
		// limit: exactly at the limit passes, one over is rejected and swallowed.
		go_idle();
		write_reg(cfp_pkg::REG_START_FIRST, 16'hFF00);
		write_reg(cfp_pkg::REG_START_SECOND, 16'h00FF);
		write_reg(cfp_pkg::REG_VERSION, 16'hFFFF);
		write_reg(cfp_pkg::REG_MAX_LEN, 16'd20);
		write_reg(REG_UNUSED, 16'h1234);
		send_frame(8'h33, 8'h44, 8'h55, 13'd10);
		send_frame(8'h66, 8'h77, 8'h88, 13'd11);
		send_frame(8'h99, 8'hAA, 8'hBB, 13'd1);

		// Zero limit: everything rejected, with and without swallowed bytes.
		go_idle();
		write_reg(cfp_pkg::REG_MAX_LEN, 16'h0000);
		send_frame(8'h01, 8'h02, 8'h03, 13'd0);
		send_frame(8'h04, 8'h05, 8'h06, 13'd1);
		send_frame(8'h07, 8'h08, 8'h09, 13'd2);

		// Random phases; the first one runs with no idling on either side.
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		random_config(16'($urandom_range(60, 10)));
		random_frames((ITEM_GOAL - DIRECTED_ITEMS) / 4);

		tx_idle_pct  = 20;
		rx_stall_pct = 60;
		random_config(16'd4106);
		random_frames((ITEM_GOAL - DIRECTED_ITEMS) / 4);

		tx_idle_pct  = 60;
		rx_stall_pct = 10;
		random_config(16'($urandom_range(65535, 70)));
		random_frames((ITEM_GOAL - DIRECTED_ITEMS) / 4);

		tx_idle_pct  = 30;
		rx_stall_pct = 30;
		random_config(16'($urandom_range(40, 10)));
		random_frames((ITEM_GOAL - DIRECTED_ITEMS) / 4);

		// Widest limit with swapped marker extremes, then a header one past the
		// payload cap. That frame's swallowed remainder is never sent; the run
		// ends with the block still dropping, which owes no output.
		go_idle();
		tx_idle_pct  = 10;
		rx_stall_pct = 10;
		write_reg(cfp_pkg::REG_START_FIRST, 16'h00FF);
		write_reg(cfp_pkg::REG_START_SECOND, 16'hFF00);
		write_reg(cfp_pkg::REG_VERSION, 16'h0000);
		write_reg(cfp_pkg::REG_MAX_LEN, 16'hFFFF);
		send_frame(8'hC0, 8'hDE, 8'h5A, 13'd40);
		send_item(8'h0F, 8'hF0, 8'h3C, 13'd4097, 8'h96);

		go_idle();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (sb.bad_count == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/cfp_pkg.sv
rtl/core/cfp_front.sv
rtl/core/cfp_cmd_queue.sv
rtl/core/cfp_back.sv
rtl/core/crc16_frame_packer_unit.sv
rtl/core/cfp_checker.sv
tb/tb_top.sv
